@@ rtl/raft_follower_progress_tracker_assert.svh @@
// Assertion macros used by the progress tracker core (rft_core)
`ifndef RAFT_FOLLOWER_PROGRESS_TRACKER_ASSERT_SVH
`define RAFT_FOLLOWER_PROGRESS_TRACKER_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define RFT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define RFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rft_pkg.sv @@
// Types and constants of the follower progress tracker
package rft_pkg;

    localparam int unsigned RFT_INFLIGHT_MAX_DEF = 256;
    localparam int unsigned RFT_CNT_W            = 9;
    localparam int unsigned RFT_IDX_W            = 64;
    localparam int unsigned RFT_APB_AW           = 3;
    localparam int unsigned RFT_APB_DW           = 32;

    localparam logic [RFT_CNT_W-1:0] RFT_MSG_LIMIT_RST = 9'd256;

    typedef enum logic [2:0] {
        OP_INIT             = 3'd0,
        OP_BECOME_PROBE     = 3'd1,
        OP_BECOME_REPLICATE = 3'd2,
        OP_BECOME_SNAPSHOT  = 3'd3,
        OP_ENTRIES_SENT     = 3'd4,
        OP_ACK              = 3'd5,
        OP_REJECT           = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        MODE_PROBE     = 2'd0,
        MODE_REPLICATE = 2'd1,
        MODE_SNAPSHOT  = 2'd2
    } mode_t;

    // Register word index on the APB port
    typedef enum logic {
        REG_MSG_LIMIT  = 1'b0,
        REG_BYTE_LIMIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] init_match;
        logic [63:0] init_next;
        logic [63:0] snapshot_index;
        logic [15:0] entry_count;
        logic [31:0] byte_count;
        logic [63:0] first_index;
        logic [63:0] acked_index;
        logic [63:0] rejected_index;
        logic [63:0] hint_index;
    } rft_in_t;

    typedef struct packed {
        logic        ok;
        mode_t       mode;
        logic [63:0] match_out;
        logic [63:0] next_out;
        logic        paused;
        logic [63:0] pending_out;
        logic [8:0]  inflight_out;
    } rft_out_t;

    typedef struct packed {
        logic [RFT_CNT_W-1:0] msg_limit;
        logic [31:0]          byte_limit;
    } rft_cfg_t;

endpackage

@@ rtl/rft_apb_regs.sv @@
// APB configuration registers of the progress tracker
module rft_apb_regs
    import rft_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [RFT_APB_AW-1:0] paddr,
    input  logic [RFT_APB_DW-1:0] pwdata,
    output logic [RFT_APB_DW-1:0] prdata,
    output logic                  pready,
    output rft_cfg_t              cfg
);

    logic [RFT_CNT_W-1:0] msg_limit_reg;
    logic [31:0]          byte_limit_reg;
    logic                 wr_en;
    reg_idx_t             sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_limit_reg  <= RFT_MSG_LIMIT_RST;
            byte_limit_reg <= '0;
        end else if (wr_en) begin
            unique case (sel)
                REG_MSG_LIMIT:  msg_limit_reg  <= pwdata[RFT_CNT_W-1:0];
                REG_BYTE_LIMIT: byte_limit_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_MSG_LIMIT:  prdata = {{(RFT_APB_DW-RFT_CNT_W){1'b0}}, msg_limit_reg};
            REG_BYTE_LIMIT: prdata = byte_limit_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.msg_limit  = msg_limit_reg;
    assign cfg.byte_limit = byte_limit_reg;

endmodule

@@ rtl/rft_core.sv @@
// Progress state registers and the per-event update logic
`include "raft_follower_progress_tracker_assert.svh"

module rft_core
    import rft_pkg::*;
#(
    parameter int unsigned INFLIGHT_MAX = RFT_INFLIGHT_MAX_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  rft_cfg_t cfg,
    input  logic     step,
    input  rft_in_t  item,
    output rft_out_t result
);

    localparam int unsigned CAP = (INFLIGHT_MAX > ((1 << RFT_CNT_W) - 1)) ?
                                  ((1 << RFT_CNT_W) - 1) : INFLIGHT_MAX;
    localparam logic [RFT_CNT_W-1:0] CAP_V = CAP[RFT_CNT_W-1:0];

    mode_t                mode_reg,    mode_next;
    logic [63:0]          match_reg,   match_next;
    logic [63:0]          next_reg,    next_next;
    logic [63:0]          pending_reg, pending_next;
    logic                 pause_reg,   pause_next;
    logic [RFT_CNT_W-1:0] count_reg,   count_next;
    logic [63:0]          bytes_reg,   bytes_next;
    logic                 ok;

    logic [RFT_CNT_W-1:0] limit;
    logic [RFT_CNT_W-1:0] count_sent;
    logic [64:0]          bytes_sum;
    logic [63:0]          bytes_sent;
    logic                 full_sent;
    logic [63:0]          match_inc;
    logic [63:0]          pend_inc;
    logic [63:0]          ack_inc;
    logic [63:0]          hint_inc;
    logic [63:0]          rej_min;

    assign limit      = (cfg.msg_limit < CAP_V) ? cfg.msg_limit : CAP_V;
    assign count_sent = (count_reg < limit) ? count_reg + 1'b1 : count_reg;
    assign bytes_sum  = {1'b0, bytes_reg} + {33'b0, item.byte_count};
    // saturate the byte total at all ones
    assign bytes_sent = bytes_sum[64] ? '1 : bytes_sum[63:0];
    assign full_sent  = (count_sent >= limit) ||
                        ((cfg.byte_limit != '0) && (bytes_sent >= {32'b0, cfg.byte_limit}));
    assign match_inc  = match_reg + 64'd1;
    assign pend_inc   = pending_reg + 64'd1;
    assign ack_inc    = item.acked_index + 64'd1;
    assign hint_inc   = item.hint_index + 64'd1;
    assign rej_min    = (item.rejected_index < hint_inc) ? item.rejected_index : hint_inc;

    always_comb begin
        mode_next    = mode_reg;
        match_next   = match_reg;
        next_next    = next_reg;
        pending_next = pending_reg;
        pause_next   = pause_reg;
        count_next   = count_reg;
        bytes_next   = bytes_reg;
        ok           = 1'b1;
        unique case (op_t'(item.op))
            OP_INIT: begin
                mode_next    = MODE_PROBE;
                match_next   = item.init_match;
                next_next    = item.init_next;
                pending_next = '0;
                pause_next   = 1'b0;
                count_next   = '0;
                bytes_next   = '0;
            end
            OP_BECOME_PROBE: begin
                mode_next    = MODE_PROBE;
                pending_next = '0;
                pause_next   = 1'b0;
                count_next   = '0;
                bytes_next   = '0;
                // leaving snapshot: skip past the pending snapshot too
                if (mode_reg == MODE_SNAPSHOT && pend_inc > match_inc) begin
                    next_next = pend_inc;
                end else begin
                    next_next = match_inc;
                end
            end
            OP_BECOME_REPLICATE: begin
                mode_next    = MODE_REPLICATE;
                next_next    = match_inc;
                pending_next = '0;
                pause_next   = 1'b0;
                count_next   = '0;
                bytes_next   = '0;
            end
            OP_BECOME_SNAPSHOT: begin
                mode_next    = MODE_SNAPSHOT;
                pending_next = item.snapshot_index;
                pause_next   = 1'b0;
                count_next   = '0;
                bytes_next   = '0;
            end
            OP_ENTRIES_SENT: begin
                if (mode_reg == MODE_REPLICATE) begin
                    if (item.entry_count != '0) begin
                        next_next  = item.first_index + {48'b0, item.entry_count};
                        count_next = count_sent;
                        bytes_next = bytes_sent;
                        pause_next = full_sent;
                    end else begin
                        pause_next = (count_reg >= limit) ||
                                     ((cfg.byte_limit != '0) &&
                                      (bytes_reg >= {32'b0, cfg.byte_limit}));
                    end
                end else if (mode_reg == MODE_PROBE) begin
                    if (item.entry_count != '0) begin
                        pause_next = 1'b1;
                    end
                end else begin
                    ok = 1'b0;
                end
            end
            OP_ACK: begin
                ok = (match_reg < item.acked_index);
                if (match_reg < item.acked_index) begin
                    match_next = item.acked_index;
                    pause_next = 1'b0;
                end
                if (ack_inc > next_reg) begin
                    next_next = ack_inc;
                end
            end
            OP_REJECT: begin
                if (mode_reg == MODE_REPLICATE) begin
                    if (item.rejected_index <= match_reg) begin
                        ok = 1'b0;
                    end else begin
                        next_next = match_inc;
                    end
                end else if ((next_reg - 64'd1) != item.rejected_index) begin
                    ok = 1'b0;
                end else begin
                    next_next  = (rej_min == '0) ? 64'd1 : rej_min;
                    pause_next = 1'b0;
                end
            end
            default: ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_PROBE;
            match_reg   <= '0;
            next_reg    <= '0;
            pending_reg <= '0;
            pause_reg   <= 1'b0;
            count_reg   <= '0;
            bytes_reg   <= '0;
        end else if (step) begin
            mode_reg    <= mode_next;
            match_reg   <= match_next;
            next_reg    <= next_next;
            pending_reg <= pending_next;
            pause_reg   <= pause_next;
            count_reg   <= count_next;
            bytes_reg   <= bytes_next;
        end
    end

    assign result.ok           = ok;
    assign result.mode         = mode_next;
    assign result.match_out    = match_next;
    assign result.next_out     = next_next;
    assign result.paused       = (mode_next == MODE_SNAPSHOT) || pause_next;
    assign result.pending_out  = pending_next;
    assign result.inflight_out = count_next;

    `RFT_ASSERT_ALWAYS(a_count_cap, count_reg <= CAP_V, "in-flight count above cap")
    `RFT_ASSERT_ALWAYS(a_snap_window, (mode_reg != MODE_SNAPSHOT) || (count_reg == '0),
        "in-flight count nonzero in snapshot mode")
    `RFT_ASSERT_ALWAYS(a_pending_snap, (mode_reg == MODE_SNAPSHOT) || (pending_reg == '0),
        "pending index set outside snapshot mode")
    `RFT_ASSERT_NEXT(a_init_clear, step && (item.op == OP_INIT),
        (mode_reg == MODE_PROBE) && (count_reg == '0) && (bytes_reg == '0),
        "init did not clear the window")

endmodule

@@ rtl/raft_follower_progress_tracker.sv @@
// Follower replication progress tracker: top level with input and result registers
//
// Usage: events enter on the s_ channel (valid/ready, payload s_data of type
// rft_in_t); each event yields exactly one result beat on the m_ channel
// (payload m_data of type rft_out_t) holding an ok flag and the updated state.
// Message and byte limits are written through the APB port (byte address 0
// and 4); the user must write them only while no event is in flight, as the
// block itself does not enforce this. Flow: an accepted event waits in the
// input register and is applied to the state at the edge that loads its
// result into the result register, which drives m_valid and m_data.
// Throughput: one event per cycle while m_ready keeps the result register
// draining, set by the single state-update stage between the two registers.
// Reset (aresetn low, synchronous) empties both registers, puts the tracker
// in probe mode with all indices and the window at zero, and loads the
// message limit with 256 and the byte limit with zero.
// When the receiver stalls, the result register holds its beat, one more
// event waits in the input register, and s_ready drops until m_ready returns.
module raft_follower_progress_tracker
    import rft_pkg::*;
#(
    parameter int unsigned INFLIGHT_MAX = RFT_INFLIGHT_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rft_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rft_out_t              m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [RFT_APB_AW-1:0] paddr,
    input  logic [RFT_APB_DW-1:0] pwdata,
    output logic [RFT_APB_DW-1:0] prdata,
    output logic                  pready
);

    rft_cfg_t cfg;
    rft_out_t result;
    rft_in_t  in_data_reg;
    rft_out_t out_data_reg;
    logic     in_valid_reg,  in_valid_next;
    logic     out_valid_reg, out_valid_next;
    logic     advance;
    logic     step;
    logic     take;

    rft_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rft_core #(
        .INFLIGHT_MAX (INFLIGHT_MAX)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .item    (in_data_reg),
        .result  (result)
    );

    // result register free or being drained this cycle
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take || (in_valid_reg && !step);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ tb/raft_follower_progress_tracker_tb.sv @@
// Self-checking testbench for the follower progress tracker
module raft_follower_progress_tracker_tb;
    import rft_pkg::*;

    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned PHASE_LEN  = 100;
    localparam int unsigned FILL_LEN   = 260;
    localparam logic [2:0]  OP_UNUSED  = 3'd7;

    class progress_scoreboard;
        mode_t       mode_q = MODE_PROBE;
        logic [63:0] match_q = '0;
        logic [63:0] next_q = '0;
        logic [63:0] pend_q = '0;
        logic [63:0] bytes_q = '0;
        bit          pause_q = 1'b0;
        int unsigned cnt_q = 0;
        int unsigned msg_limit_cfg = 256;
        logic [31:0] byte_limit_cfg = '0;
        rft_out_t    expected_progress[$];
        int unsigned errors = 0;

        function void set_limit(reg_idx_t idx, logic [31:0] val);
            if (idx == REG_MSG_LIMIT) msg_limit_cfg = val[8:0];
            else byte_limit_cfg = val;
        endfunction

        function void enter_mode(mode_t m);
            pause_q = 1'b0;
            pend_q  = '0;
            mode_q  = m;
            cnt_q   = 0;
            bytes_q = '0;
        endfunction

        // Advance the tracked state by one event and queue the resulting beat
        function void note_event(rft_in_t ev);
            rft_out_t    r;
            bit          ok;
            bit          was_snap;
            int unsigned cap;
            logic [64:0] sum;
            logic [63:0] h, m, pend;
            ok  = 1'b1;
            cap = (msg_limit_cfg < RFT_INFLIGHT_MAX_DEF) ? msg_limit_cfg : RFT_INFLIGHT_MAX_DEF;
            case (ev.op)
                OP_INIT: begin
                    enter_mode(MODE_PROBE);
                    match_q = ev.init_match;
                    next_q  = ev.init_next;
                end
                OP_BECOME_PROBE: begin
                    was_snap = (mode_q == MODE_SNAPSHOT);
                    pend     = pend_q;
                    enter_mode(MODE_PROBE);
                    next_q = match_q + 64'd1;
                    if (was_snap && (pend + 64'd1) > next_q) next_q = pend + 64'd1;
                end
                OP_BECOME_REPLICATE: begin
                    enter_mode(MODE_REPLICATE);
                    next_q = match_q + 64'd1;
                end
                OP_BECOME_SNAPSHOT: begin
                    enter_mode(MODE_SNAPSHOT);
                    pend_q = ev.snapshot_index;
                end
                OP_ENTRIES_SENT: begin
                    if (mode_q == MODE_REPLICATE) begin
                        if (ev.entry_count != 0) begin
                            next_q = ev.first_index + 64'(ev.entry_count);
                            if (cnt_q < cap) cnt_q++;
                            sum = {1'b0, bytes_q} + 65'(ev.byte_count);
                            bytes_q = sum[64] ? '1 : sum[63:0];
                        end
                        pause_q = (cnt_q >= cap) ||
                                  (byte_limit_cfg != 0 && bytes_q >= 64'(byte_limit_cfg));
                    end else if (mode_q == MODE_PROBE) begin
                        if (ev.entry_count != 0) pause_q = 1'b1;
                    end else begin
                        ok = 1'b0;
                    end
                end
                OP_ACK: begin
                    ok = 1'b0;
                    if (match_q < ev.acked_index) begin
                        match_q = ev.acked_index;
                        ok      = 1'b1;
                        pause_q = 1'b0;
                    end
                    h = ev.acked_index + 64'd1;
                    if (h > next_q) next_q = h;
                end
                OP_REJECT: begin
                    if (mode_q == MODE_REPLICATE) begin
                        if (ev.rejected_index <= match_q) ok = 1'b0;
                        else next_q = match_q + 64'd1;
                    end else if (next_q - 64'd1 != ev.rejected_index) begin
                        ok = 1'b0;
                    end else begin
                        h = ev.hint_index + 64'd1;
                        m = (ev.rejected_index < h) ? ev.rejected_index : h;
                        next_q  = (m == 0) ? 64'd1 : m;
                        pause_q = 1'b0;
                    end
                end
                default: ok = 1'b0;
            endcase
            r.ok           = ok;
            r.mode         = mode_q;
            r.match_out    = match_q;
            r.next_out     = next_q;
            r.paused       = (mode_q == MODE_SNAPSHOT) || pause_q;
            r.pending_out  = pend_q;
            r.inflight_out = cnt_q[8:0];
            expected_progress.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_progress(rft_out_t got);
            rft_out_t want;
            if (expected_progress.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat: expected none, got %0h", $time, got);
                return;
            end
            want = expected_progress.pop_front();
            compare_field("ok", 64'(want.ok), 64'(got.ok));
            compare_field("mode", 64'(want.mode), 64'(got.mode));
            compare_field("match_out", want.match_out, got.match_out);
            compare_field("next_out", want.next_out, got.next_out);
            compare_field("paused", 64'(want.paused), 64'(got.paused));
            compare_field("pending_out", want.pending_out, got.pending_out);
            compare_field("inflight_out", 64'(want.inflight_out), 64'(got.inflight_out));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    rft_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rft_out_t              m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [RFT_APB_AW-1:0] paddr = '0;
    logic [RFT_APB_DW-1:0] pwdata = '0;
    logic [RFT_APB_DW-1:0] prdata;
    logic                  pready;

    progress_scoreboard sb = new;
    int unsigned        cycles = 0;
    int unsigned        events_sent = 0;
    bit                 calm = 1'b0;

    raft_follower_progress_tracker #(
        .INFLIGHT_MAX(RFT_INFLIGHT_MAX_DEF)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_progress(m_data);
    end

    // Result side: one long hold-off to back up the input, then random stalls
    initial begin
        wait (aresetn);
        @(posedge aclk);
        m_ready <= 1'b1;
        wait (events_sent >= 60);
        @(posedge aclk);
        m_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic rft_in_t rand_event(logic [2:0] op);
        rft_in_t ev;
        ev.op             = op;
        ev.init_match     = rnd64();
        ev.init_next      = rnd64();
        ev.snapshot_index = rnd64();
        ev.entry_count    = 16'($urandom);
        ev.byte_count     = $urandom;
        ev.first_index    = rnd64();
        ev.acked_index    = rnd64();
        ev.rejected_index = rnd64();
        ev.hint_index     = rnd64();
        return ev;
    endfunction

    // Mostly events that make sense for the current state, some pure noise
    function automatic rft_in_t pick_event();
        rft_in_t     ev;
        int unsigned sel;
        logic [63:0] base;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            ev = rand_event(3'($urandom_range(0, 7)));
        end else if (sel < 12) begin
            ev = rand_event(OP_INIT);
            base = ($urandom_range(0, 3) == 0) ? rnd64() : 64'($urandom_range(0, 1000));
            ev.init_match = base;
            ev.init_next  = base + 64'($urandom_range(0, 3));
        end else if (sel < 22) begin
            ev = rand_event(3'($urandom_range(OP_BECOME_PROBE, OP_BECOME_SNAPSHOT)));
            if ($urandom_range(0, 3) != 0)
                ev.snapshot_index = sb.match_q + 64'($urandom_range(0, 50));
        end else if (sel < 55) begin
            ev = rand_event(OP_ENTRIES_SENT);
            ev.first_index = sb.next_q;
            if ($urandom_range(0, 9) != 0) begin
                ev.entry_count = 16'($urandom_range(0, 6));
                ev.byte_count  = $urandom_range(0, 3000);
            end
        end else if (sel < 80) begin
            ev = rand_event(OP_ACK);
            if ($urandom_range(0, 7) != 0)
                ev.acked_index = sb.match_q + 64'($urandom_range(0, 10)) - 64'd2;
        end else begin
            ev = rand_event(OP_REJECT);
            if (sb.mode_q == MODE_REPLICATE)
                ev.rejected_index = sb.match_q + 64'($urandom_range(0, 4)) - 64'd1;
            else if ($urandom_range(0, 4) != 0)
                ev.rejected_index = sb.next_q - 64'd1;
            else
                ev.rejected_index = sb.next_q + 64'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
                ev.hint_index = ev.rejected_index - 64'($urandom_range(0, 10));
        end
        return ev;
    endfunction

    task automatic send_event(input rft_in_t ev);
        s_data  <= ev;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(ev);
        events_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic drain_events();
        s_valid <= 1'b0;
        while (sb.expected_progress.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_limit(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        rft_in_t     d;
        int unsigned msg_cfg[7];
        logic [31:0] byte_cfg[7];

        msg_cfg  = '{4, 0, 1, 511, 256, 8, 300};
        byte_cfg = '{0, 0, 5000, 32'hFFFF_FFFF, 1, 20000, 0};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: wraparound, stale events, mode transitions
        d = rand_event(OP_INIT);
        d.init_match = '1;
        d.init_next  = '1;
        send_event(d);
        d = rand_event(OP_ACK);
        d.acked_index = '0;
        send_event(d);
        d = rand_event(OP_REJECT);
        d.rejected_index = 64'hFFFF_FFFF_FFFF_FFFE;
        d.hint_index     = '1;
        send_event(d);
        send_event(rand_event(OP_BECOME_PROBE));
        d = rand_event(OP_INIT);
        d.init_match = '0;
        d.init_next  = '0;
        send_event(d);
        d = rand_event(OP_REJECT);
        d.rejected_index = '1;
        d.hint_index     = 64'd5;
        send_event(d);
        d = rand_event(OP_REJECT);
        d.rejected_index = 64'd3;
        send_event(d);
        d = rand_event(OP_ENTRIES_SENT);
        d.entry_count = '0;
        send_event(d);
        d.entry_count = '1;
        send_event(d);
        d = rand_event(OP_ACK);
        d.acked_index = 64'd10;
        send_event(d);
        send_event(rand_event(OP_BECOME_REPLICATE));
        d = rand_event(OP_ENTRIES_SENT);
        d.entry_count = '1;
        d.byte_count  = '1;
        d.first_index = '1;
        send_event(d);
        d.entry_count = '0;
        send_event(d);
        d = rand_event(OP_REJECT);
        d.rejected_index = 64'd10;
        send_event(d);
        d.rejected_index = '1;
        send_event(d);
        d = rand_event(OP_ACK);
        d.acked_index = '1;
        send_event(d);
        d = rand_event(OP_BECOME_SNAPSHOT);
        d.snapshot_index = '1;
        send_event(d);
        send_event(rand_event(OP_ENTRIES_SENT));
        d = rand_event(OP_ACK);
        d.acked_index = 64'd5;
        send_event(d);
        send_event(rand_event(OP_BECOME_PROBE));
        d = rand_event(OP_BECOME_SNAPSHOT);
        d.snapshot_index = 64'd100;
        send_event(d);
        send_event(rand_event(OP_BECOME_PROBE));
        send_event(rand_event(OP_UNUSED));

        for (int p = 0; p < 7; p++) begin
            drain_events();
            if (p == 6) begin
                calm = 1'b1;
                write_reg(REG_MSG_LIMIT, $urandom_range(2, 300));
                write_reg(REG_BYTE_LIMIT, $urandom_range(0, 60000));
            end else begin
                write_reg(REG_MSG_LIMIT, msg_cfg[p]);
                write_reg(REG_BYTE_LIMIT, byte_cfg[p]);
            end
            // Push the count into the cap when the phase's msg_cfg entry exceeds it
            if (msg_cfg[p] > RFT_INFLIGHT_MAX_DEF) begin
                send_event(rand_event(OP_BECOME_REPLICATE));
                repeat (FILL_LEN) begin
                    d = rand_event(OP_ENTRIES_SENT);
                    d.entry_count = 16'($urandom_range(1, 4));
                    d.byte_count  = $urandom_range(0, 100);
                    d.first_index = sb.next_q;
                    send_event(d);
                end
            end
            repeat (PHASE_LEN) send_event(pick_event());
        end

        drain_events();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_progress.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ raft_follower_progress_tracker.f @@
+incdir+rtl
rtl/rft_pkg.sv
rtl/rft_apb_regs.sv
rtl/rft_core.sv
rtl/raft_follower_progress_tracker.sv
tb/raft_follower_progress_tracker_tb.sv
